>>> hdl/dsds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_pkg
// Shared types, constants and the coil phase table for the dual stepper
// drive sequencer.
// ----------------------------------------------------------------------------
package dsds_pkg;

	localparam int COUNT_W    = 16;
	localparam int PERIOD_W   = 16;
	localparam int QUO_W      = 16;
	localparam int REM_W      = 7;
	localparam int ACC_W      = QUO_W + REM_W;
	localparam int MUL_A_W    = 16;
	localparam int MUL_B_W    = 7;
	localparam int RECIP_W    = 24;
	localparam int SCALE_W    = ACC_W + RECIP_W;
	localparam int RECIP_SH   = 30;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// x / 100 == (x * ceil(2^30 / 100)) >> 30 for every x below 2^23
	localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
	localparam logic [MUL_B_W-1:0] PCT_FULL = 7'd100;

	localparam logic REG_MIN_PERIOD = 1'b0;
	localparam logic REG_MAX_PERIOD = 1'b1;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_DRIVE  = 2'd1,
		OP_ROTATE = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SPEED_BAD = 2'd1,
		ST_DIR_BAD   = 2'd2
	} status_t;

	typedef struct packed {
		logic                 start;
		logic [MUL_A_W-1:0]   a1;
		logic [MUL_B_W-1:0]   b1;
		logic [MUL_A_W-1:0]   a2;
		logic [MUL_B_W-1:0]   b2;
	} mdu_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} mdu_rsp_t;

	typedef struct packed {
		logic                load;
		logic signed [7:0]   speed;
		logic [PERIOD_W-1:0] period;
		logic                tick;
		logic                halt;
	} mot_ctrl_t;

	typedef struct packed {
		logic [COUNT_W-1:0] steps;
		logic [COUNT_W-1:0] steps_next;
		logic [3:0]         coil;
	} mot_stat_t;

	// wave drive: left walks 8,2,4,1, right walks 1,4,2,8; reversed walks backward
	function automatic logic [3:0] phase_coil(input logic side, input logic rev,
		input logic [1:0] ph);
		logic [1:0] p;
		logic [3:0] c;
		p = rev ? ~ph : ph;
		case ({side, p})
			3'b000:  c = 4'd8;
			3'b001:  c = 4'd2;
			3'b010:  c = 4'd4;
			3'b011:  c = 4'd1;
			3'b100:  c = 4'd1;
			3'b101:  c = 4'd4;
			3'b110:  c = 4'd2;
			3'b111:  c = 4'd8;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

endpackage

>>> hdl/dsds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_if
// Command and result channels of the dual stepper drive sequencer.
// ----------------------------------------------------------------------------
interface dsds_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [7:0]  speed;
	logic signed [8:0]  direction;
	logic [15:0]        step_limit;

	modport source (output valid, op, speed, direction, step_limit, input ready);
	modport sink (input valid, op, speed, direction, step_limit, output ready);
endinterface

interface dsds_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  coils_left;
	logic [3:0]  coils_right;
	logic        running;
	logic [1:0]  status;
	logic [15:0] steps_left;
	logic [15:0] steps_right;

	modport source (output valid, coils_left, coils_right, running, status,
		steps_left, steps_right, input ready);
	modport sink (input valid, coils_left, coils_right, running, status,
		steps_left, steps_right, output ready);
endinterface

>>> hdl/dsds_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_apb_regs
// APB register file holding the minimum and maximum step periods.
// ----------------------------------------------------------------------------
module dsds_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsds_pkg::ADDR_W-1:0]   paddr,
	input  logic [dsds_pkg::DATA_W-1:0]   pwdata,
	output logic [dsds_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [dsds_pkg::PERIOD_W-1:0] min_period,
	output logic [dsds_pkg::PERIOD_W-1:0] max_period
);

	logic [dsds_pkg::PERIOD_W-1:0] min_q;
	logic [dsds_pkg::PERIOD_W-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'd5;
			max_q <= 16'd50;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				dsds_pkg::REG_MIN_PERIOD: min_q <= pwdata[dsds_pkg::PERIOD_W-1:0];
				dsds_pkg::REG_MAX_PERIOD: max_q <= pwdata[dsds_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dsds_pkg::REG_MIN_PERIOD: prdata = dsds_pkg::DATA_W'(min_q);
			dsds_pkg::REG_MAX_PERIOD: prdata = dsds_pkg::DATA_W'(max_q);
			default:                  prdata = '0;
		endcase
	end

	assign pready     = 1'b1;
	assign min_period = min_q;
	assign max_period = max_q;

endmodule

>>> hdl/dsds_mdu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_mdu
// Shared arithmetic unit: (a1*b1 + a2*b2) / 100, one multiplier used twice,
// then the divide by 100 as a multiply by the scaled reciprocal.
// ----------------------------------------------------------------------------
module dsds_mdu (
	input  logic                clk,
	input  logic                arst_n,
	input  dsds_pkg::mdu_req_t  req,
	output dsds_pkg::mdu_rsp_t  rsp
);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_MUL  = 3'b010,
		U_DIV  = 3'b100
	} ustate_t;

	ustate_t                           state_q;
	logic [dsds_pkg::MUL_A_W-1:0]      a2_q;
	logic [dsds_pkg::MUL_B_W-1:0]      b2_q;
	logic [dsds_pkg::ACC_W-1:0]        acc_q;
	logic [dsds_pkg::ACC_W-1:0]        sum_q;
	logic [dsds_pkg::QUO_W-1:0]        quo_q;
	logic                              done_q;

	logic [dsds_pkg::MUL_A_W-1:0]      m_a;
	logic [dsds_pkg::MUL_B_W-1:0]      m_b;
	logic [dsds_pkg::ACC_W-1:0]        prod;
	logic [dsds_pkg::ACC_W-1:0]        sum;
	logic [dsds_pkg::SCALE_W-1:0]      scaled;

	assign m_a    = (state_q == U_MUL) ? a2_q : req.a1;
	assign m_b    = (state_q == U_MUL) ? b2_q : req.b1;
	assign prod   = dsds_pkg::ACC_W'(m_a) * dsds_pkg::ACC_W'(m_b);
	assign sum    = acc_q + prod;
	assign scaled = dsds_pkg::SCALE_W'(sum_q) * dsds_pkg::SCALE_W'(dsds_pkg::RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				U_IDLE: begin
					done_q <= 1'b0;
					if (req.start) begin
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					done_q  <= 1'b0;
					state_q <= U_DIV;
				end
				U_DIV: begin
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				acc_q <= prod;
				a2_q  <= req.a2;
				b2_q  <= req.b2;
			end
			U_MUL: begin
				sum_q <= sum;
			end
			U_DIV: begin
				quo_q <= scaled[dsds_pkg::RECIP_SH +: dsds_pkg::QUO_W];
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> hdl/dsds_motor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_motor
// One motor: speed, period, countdown, step count and coil phase.
// ----------------------------------------------------------------------------
module dsds_motor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 side,
	input  dsds_pkg::mot_ctrl_t  ctrl,
	output dsds_pkg::mot_stat_t  stat
);

	logic signed [7:0]                speed_q;
	logic [dsds_pkg::PERIOD_W-1:0]    period_q;
	logic [dsds_pkg::PERIOD_W-1:0]    cnt_q;
	logic [dsds_pkg::COUNT_W-1:0]     steps_q;
	logic [3:0]                       coil_q;

	logic                             active;
	logic                             step_due;
	logic [dsds_pkg::COUNT_W-1:0]     steps_inc;
	logic [dsds_pkg::PERIOD_W-1:0]    reload;
	logic [dsds_pkg::PERIOD_W-1:0]    load_cnt;

	assign active    = ctrl.tick && (speed_q != 8'sd0);
	assign step_due  = active && (cnt_q <= dsds_pkg::PERIOD_W'(1));
	assign steps_inc = steps_q + dsds_pkg::COUNT_W'(1);
	assign reload    = (period_q == '0) ? dsds_pkg::PERIOD_W'(1) : period_q;
	assign load_cnt  = (ctrl.period == '0) ? dsds_pkg::PERIOD_W'(1) : ctrl.period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= '0;
			period_q <= '0;
			cnt_q    <= '0;
			steps_q  <= '0;
			coil_q   <= '0;
		end else if (ctrl.load) begin
			speed_q  <= ctrl.speed;
			period_q <= ctrl.period;
			cnt_q    <= load_cnt;
			steps_q  <= '0;
			coil_q   <= (ctrl.speed != 8'sd0) ?
				dsds_pkg::phase_coil(side, ctrl.speed[7], 2'b00) : 4'd0;
		end else begin
			if (step_due) begin
				steps_q <= steps_inc;
				cnt_q   <= reload;
			end else if (active) begin
				cnt_q <= cnt_q - dsds_pkg::PERIOD_W'(1);
			end
			if (ctrl.halt) begin
				coil_q <= '0;
			end else if (step_due) begin
				coil_q <= dsds_pkg::phase_coil(side, speed_q[7], steps_inc[1:0]);
			end
		end
	end

	assign stat.steps      = steps_q;
	assign stat.steps_next = step_due ? steps_inc : steps_q;
	assign stat.coil       = coil_q;

	a_load_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> (steps_q == '0))
		else $error("step count not cleared by load");

	a_halt_clears_coil: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.halt && !ctrl.load) |=> (coil_q == 4'd0))
		else $error("coil not cleared by halt");

endmodule

>>> hdl/dual_stepper_drive_sequencer_core.sv
`timescale 1ns / 1ps
// Tick, stop and rejected commands go from S_EXEC straight to S_FIN for their result.
// Rotate runs two step-period jobs on the shared multiply / divide-by-100 unit (two
// products, one reciprocal multiply each); drive first runs the speed mix on it too.
// One transaction at a time; the next command is taken the cycle after the result is
// registered, and waits while an earlier result is still held.
// Reset (arst_n low) clears all motor state and restores periods 5 ms and 50 ms at once.
// ----------------------------------------------------------------------------
// dual_stepper_drive_sequencer_core
// Command sequencer for two wave-drive steppers: validates and mixes commands,
// computes step periods on a shared arithmetic unit and steps on ticks.
// ----------------------------------------------------------------------------
module dual_stepper_drive_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	dsds_cmd_if.sink                      cmd,
	dsds_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dsds_pkg::ADDR_W-1:0]   paddr,
	input  logic [dsds_pkg::DATA_W-1:0]   pwdata,
	output logic [dsds_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_MIX  = 8'b0000_0100,
		S_P0GO = 8'b0000_1000,
		S_P0   = 8'b0001_0000,
		S_P1GO = 8'b0010_0000,
		S_P1   = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t                         state_q;
	logic [1:0]                     op_q;
	logic signed [7:0]              speed_q;
	logic signed [8:0]              dir_q;
	logic [15:0]                    lim_in_q;
	logic [1:0]                     status_q;
	logic                           run_q;
	logic [15:0]                    limit_q;
	logic signed [7:0]              sp0_q;
	logic signed [7:0]              sp1_q;

	logic                           res_valid_q;
	logic [3:0]                     coils_l_q;
	logic [3:0]                     coils_r_q;
	logic                           running_q;
	logic [1:0]                     res_status_q;
	logic [15:0]                    steps_l_q;
	logic [15:0]                    steps_r_q;

	logic [dsds_pkg::PERIOD_W-1:0]  min_period;
	logic [dsds_pkg::PERIOD_W-1:0]  max_period;
	dsds_pkg::mdu_req_t             mreq;
	dsds_pkg::mdu_rsp_t             mrsp;
	dsds_pkg::mot_ctrl_t            ctl0;
	dsds_pkg::mot_ctrl_t            ctl1;
	dsds_pkg::mot_stat_t            st0;
	dsds_pkg::mot_stat_t            st1;

	logic                           speed_bad;
	logic                           drive_bad;
	logic                           rot_ok;
	logic [7:0]                     spd_mag;
	logic [8:0]                     dir_mag;
	logic [7:0]                     mix_mag;
	logic signed [7:0]              mixed;
	logic signed [7:0]              per_sp;
	logic [7:0]                     per_mag;
	logic                           do_tick;
	logic                           do_stop;
	logic                           limit_hit;
	logic                           res_free;

	dsds_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.min_period (min_period),
		.max_period (max_period)
	);

	dsds_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	dsds_motor u_motor_left (
		.clk    (clk),
		.arst_n (arst_n),
		.side   (dsds_pkg::SIDE_LEFT),
		.ctrl   (ctl0),
		.stat   (st0)
	);

	dsds_motor u_motor_right (
		.clk    (clk),
		.arst_n (arst_n),
		.side   (dsds_pkg::SIDE_RIGHT),
		.ctrl   (ctl1),
		.stat   (st1)
	);

	// command checks
	assign speed_bad = (speed_q > 8'sd100) || (speed_q < -8'sd100);
	assign drive_bad = (dir_q > 9'sd100) || (dir_q < -9'sd100);
	assign rot_ok    = (dir_q == 9'sd90) || (dir_q == -9'sd90) ||
	                   (dir_q == 9'sd180) || (dir_q == -9'sd180);
	assign spd_mag   = speed_q[7] ? 8'(-speed_q) : 8'(speed_q);
	assign dir_mag   = dir_q[8] ? 9'(-dir_q) : 9'(dir_q);

	// slowed motor: sign(speed) * trunc(|speed| * (100 - |dir|) / 100)
	assign mix_mag = mrsp.quo[7:0];
	assign mixed   = speed_q[7] ? 8'(-mix_mag) : 8'(mix_mag);

	assign per_sp  = (state_q == S_P0GO) ? sp0_q : sp1_q;
	assign per_mag = per_sp[7] ? 8'(-per_sp) : 8'(per_sp);

	// period * 100 = min * |s| + max * (100 - |s|)
	always_comb begin
		mreq.start = 1'b0;
		if (state_q == S_EXEC) begin
			mreq.start = (op_q == dsds_pkg::OP_DRIVE) && !speed_bad && !drive_bad;
			mreq.a1    = dsds_pkg::MUL_A_W'(spd_mag[6:0]);
			mreq.b1    = dsds_pkg::PCT_FULL - dir_mag[6:0];
			mreq.a2    = '0;
			mreq.b2    = '0;
		end else begin
			mreq.start = (state_q == S_P0GO) || (state_q == S_P1GO);
			mreq.a1    = min_period;
			mreq.b1    = per_mag[6:0];
			mreq.a2    = max_period;
			mreq.b2    = dsds_pkg::PCT_FULL - per_mag[6:0];
		end
	end

	assign do_tick   = (state_q == S_EXEC) && (op_q == dsds_pkg::OP_TICK) && run_q;
	assign do_stop   = (state_q == S_EXEC) && (op_q == dsds_pkg::OP_STOP);
	assign limit_hit = (limit_q != 16'd0) &&
		((32'(st0.steps_next) == 32'(limit_q)) || (32'(st1.steps_next) == 32'(limit_q)));

	always_comb begin
		ctl0.load   = (state_q == S_P0) && mrsp.done;
		ctl0.speed  = sp0_q;
		ctl0.period = mrsp.quo;
		ctl0.tick   = do_tick;
		ctl0.halt   = do_stop || (do_tick && limit_hit);
		ctl1.load   = (state_q == S_P1) && mrsp.done;
		ctl1.speed  = sp1_q;
		ctl1.period = mrsp.quo;
		ctl1.tick   = do_tick;
		ctl1.halt   = do_stop || (do_tick && limit_hit);
	end

	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_q       <= 1'b0;
			limit_q     <= '0;
			status_q    <= dsds_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && (state_q != S_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						dsds_pkg::OP_TICK: begin
							status_q <= dsds_pkg::ST_OK;
							state_q  <= S_FIN;
							if (do_tick && limit_hit) begin
								run_q <= 1'b0;
							end
						end
						dsds_pkg::OP_STOP: begin
							status_q <= dsds_pkg::ST_OK;
							state_q  <= S_FIN;
							run_q    <= 1'b0;
						end
						dsds_pkg::OP_DRIVE: begin
							if (speed_bad) begin
								status_q <= dsds_pkg::ST_SPEED_BAD;
								state_q  <= S_FIN;
							end else if (drive_bad) begin
								status_q <= dsds_pkg::ST_DIR_BAD;
								state_q  <= S_FIN;
							end else begin
								status_q <= dsds_pkg::ST_OK;
								state_q  <= S_MIX;
							end
						end
						dsds_pkg::OP_ROTATE: begin
							if (speed_bad) begin
								status_q <= dsds_pkg::ST_SPEED_BAD;
								state_q  <= S_FIN;
							end else if (!rot_ok) begin
								status_q <= dsds_pkg::ST_DIR_BAD;
								state_q  <= S_FIN;
							end else begin
								status_q <= dsds_pkg::ST_OK;
								state_q  <= S_P0GO;
							end
						end
						default: begin
							status_q <= dsds_pkg::ST_OK;
							state_q  <= S_FIN;
						end
					endcase
				end
				S_MIX: begin
					if (mrsp.done) begin
						state_q <= S_P0GO;
					end
				end
				S_P0GO: state_q <= S_P0;
				S_P0: begin
					if (mrsp.done) begin
						state_q <= S_P1GO;
					end
				end
				S_P1GO: state_q <= S_P1;
				S_P1: begin
					if (mrsp.done) begin
						run_q   <= 1'b1;
						limit_q <= lim_in_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command capture, motor speeds and result payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && cmd.valid) begin
			op_q     <= cmd.op;
			speed_q  <= cmd.speed;
			dir_q    <= cmd.direction;
			lim_in_q <= cmd.step_limit;
		end
		if ((state_q == S_EXEC) && (op_q == dsds_pkg::OP_ROTATE)) begin
			sp0_q <= speed_q;
			sp1_q <= 8'(-speed_q);
		end
		if ((state_q == S_MIX) && mrsp.done) begin
			if (dir_q[8]) begin
				sp0_q <= mixed;
				sp1_q <= speed_q;
			end else begin
				sp0_q <= speed_q;
				sp1_q <= mixed;
			end
		end
		if ((state_q == S_FIN) && res_free) begin
			coils_l_q    <= st0.coil;
			coils_r_q    <= st1.coil;
			running_q    <= run_q;
			res_status_q <= status_q;
			steps_l_q    <= st0.steps[15:0];
			steps_r_q    <= st1.steps[15:0];
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign res.valid       = res_valid_q;
	assign res.coils_left  = coils_l_q;
	assign res.coils_right = coils_r_q;
	assign res.running     = running_q;
	assign res.status      = res_status_q;
	assign res.steps_left  = steps_l_q;
	assign res.steps_right = steps_r_q;

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> ((state_q == S_MIX) || (state_q == S_P0) || (state_q == S_P1)))
		else $error("arithmetic unit finished outside a wait state");

	a_idle_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && !run_q) |-> ((st0.coil == 4'd0) && (st1.coil == 4'd0)))
		else $error("coils driven while not running");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside finish state");

endmodule

>>> tb/tb_dual_stepper_drive_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_stepper_drive_sequencer_core
// Self-checking bench for the dual stepper drive sequencer. A directed table
// covers reset state, rejected commands, mixing, rotation and step limits.
// Random segments under several period settings and flow-control patterns
// follow. Every result transaction is compared field by field against a
// behavioral predictor, or against the table's report for typed rows.
// ----------------------------------------------------------------------------
module tb_dual_stepper_drive_sequencer_core;

	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 200;
	localparam int SEG_ITEMS     = 50;
	localparam int NUM_SEGS      = 10;

	localparam logic [3:0] WAVE_SEQ [2][4] = '{
		'{4'd8, 4'd2, 4'd4, 4'd1},
		'{4'd1, 4'd4, 4'd2, 4'd8}
	};
	localparam int ROT_ANGLES [4] = '{90, -90, 180, -180};

	typedef struct packed {
		dsds_pkg::op_t      op;
		logic signed [7:0]  speed;
		logic signed [8:0]  dir;
		logic [15:0]        limit;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0]          coils_l;
		logic [3:0]          coils_r;
		logic                running;
		dsds_pkg::status_t   status;
		logic [15:0]         steps_l;
		logic [15:0]         steps_r;
	} drive_report_t;

	typedef struct packed {
		cmd_word_t     cmd;
		logic          typed;
		drive_report_t want;
	} directed_row_t;

	localparam drive_report_t IDLE_REPORT =
		'{4'd0, 4'd0, 1'b0, dsds_pkg::ST_OK, 16'd0, 16'd0};
	localparam drive_report_t SPD_REPORT =
		'{4'd0, 4'd0, 1'b0, dsds_pkg::ST_SPEED_BAD, 16'd0, 16'd0};
	localparam drive_report_t DIR_REPORT =
		'{4'd0, 4'd0, 1'b0, dsds_pkg::ST_DIR_BAD, 16'd0, 16'd0};
	localparam drive_report_t SPIN_REPORT =
		'{4'd8, 4'd8, 1'b1, dsds_pkg::ST_OK, 16'd0, 16'd0};
	localparam drive_report_t HOLD_REPORT =
		'{4'd8, 4'd8, 1'b1, dsds_pkg::ST_DIR_BAD, 16'd0, 16'd0};
	localparam drive_report_t STILL_REPORT =
		'{4'd0, 4'd0, 1'b1, dsds_pkg::ST_OK, 16'd0, 16'd0};

	localparam directed_row_t DIRECTED [26] = '{
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b1, IDLE_REPORT},
		'{'{dsds_pkg::OP_STOP,   8'sd0,    9'sd0,    16'd0},     1'b1, IDLE_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  8'sd127,  9'sd0,    16'd0},     1'b1, SPD_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  8'h80,    9'sd0,    16'd0},     1'b1, SPD_REPORT},
		'{'{dsds_pkg::OP_ROTATE, 8'sd101,  9'sd90,   16'd0},     1'b1, SPD_REPORT},
		'{'{dsds_pkg::OP_ROTATE, -8'sd101, 9'sd45,   16'd0},     1'b1, SPD_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  8'sd100,  9'sd255,  16'd0},     1'b1, DIR_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  -8'sd100, 9'h100,   16'd0},     1'b1, DIR_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  8'sd50,   9'sd101,  16'd0},     1'b1, DIR_REPORT},
		'{'{dsds_pkg::OP_ROTATE, 8'sd100,  -9'sd180, 16'd1},     1'b1, SPIN_REPORT},
		'{'{dsds_pkg::OP_ROTATE, 8'sd100,  9'sd89,   16'd0},     1'b1, HOLD_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  -8'sd100, -9'sd100, 16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  8'sd37,   9'sd63,   16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  -8'sd37,  -9'sd63,  16'd7},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_DRIVE,  8'sd0,    9'sd0,    16'd5},     1'b1, STILL_REPORT},
		'{'{dsds_pkg::OP_TICK,   8'sd0,    9'sd0,    16'd0},     1'b1, STILL_REPORT},
		'{'{dsds_pkg::OP_STOP,   8'sd0,    9'sd0,    16'd0},     1'b1, IDLE_REPORT},
		'{'{dsds_pkg::OP_ROTATE, -8'sd100, 9'sd90,   16'd65535}, 1'b0, IDLE_REPORT},
		'{'{dsds_pkg::OP_ROTATE, 8'sd1,    -9'sd90,  16'd0},     1'b0, IDLE_REPORT}
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [dsds_pkg::ADDR_W-1:0]   paddr;
	logic [dsds_pkg::DATA_W-1:0]   pwdata;
	logic [dsds_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	dsds_cmd_if cmd_ch ();
	dsds_res_if res_ch ();

	dual_stepper_drive_sequencer_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [15:0] min_ms = 16'd5;
	logic [15:0] max_ms = 16'd50;
	logic        run_on = 1'b0;
	int          mot_speed [2] = '{0, 0};
	logic [15:0] mot_per [2] = '{16'd0, 16'd0};
	logic [15:0] mot_cnt [2] = '{16'd0, 16'd0};
	logic [15:0] mot_steps [2] = '{16'd0, 16'd0};
	logic [3:0]  mot_coil [2] = '{4'd0, 4'd0};
	logic [15:0] lim_steps = 16'd0;

	drive_report_t pending_reports [$];
	int            mismatch_cnt = 0;
	int            src_idle_pct = 0;
	int            snk_idle_pct = 0;
	int            hold_requests = 0;

	function automatic logic [3:0] wave_coil(input int m);
		logic [1:0] ph;
		ph = mot_steps[m][1:0];
		if (mot_speed[m] < 0)
			ph = 2'd3 - ph;
		return WAVE_SEQ[m][ph];
	endfunction

	function automatic void stop_motors();
		run_on = 1'b0;
		mot_coil[0] = 4'd0;
		mot_coil[1] = 4'd0;
	endfunction

	function automatic void launch_run(input int s0, input int s1, input logic [15:0] lim);
		int     sp [2];
		longint mag;
		longint val;
		sp[0] = s0;
		sp[1] = s1;
		stop_motors();
		for (int m = 0; m < 2; m++) begin
			mag = sp[m] < 0 ? -sp[m] : sp[m];
			val = longint'(min_ms) * 100 + (longint'(max_ms) - longint'(min_ms)) * (100 - mag);
			mot_speed[m] = sp[m];
			mot_steps[m] = 16'd0;
			mot_per[m] = 16'(val / 100);
			mot_cnt[m] = mot_per[m] == 16'd0 ? 16'd1 : mot_per[m];
			mot_coil[m] = sp[m] != 0 ? wave_coil(m) : 4'd0;
		end
		lim_steps = lim;
		run_on = 1'b1;
	endfunction

	function automatic void advance_ms();
		if (!run_on)
			return;
		for (int m = 0; m < 2; m++) begin
			if (mot_speed[m] == 0)
				continue;
			if (mot_cnt[m] <= 16'd1) begin
				mot_steps[m] = mot_steps[m] + 16'd1;
				mot_coil[m] = wave_coil(m);
				mot_cnt[m] = mot_per[m] == 16'd0 ? 16'd1 : mot_per[m];
			end else begin
				mot_cnt[m] = mot_cnt[m] - 16'd1;
			end
		end
		if (lim_steps != 16'd0 && (mot_steps[0] == lim_steps || mot_steps[1] == lim_steps))
			stop_motors();
	endfunction

	function automatic drive_report_t predict_report(input cmd_word_t c);
		drive_report_t r;
		int            spd;
		int            dir;
		spd = int'($signed(c.speed));
		dir = int'($signed(c.dir));
		r.status = dsds_pkg::ST_OK;
		case (c.op)
			dsds_pkg::OP_TICK: advance_ms();
			dsds_pkg::OP_STOP: stop_motors();
			default: begin
				if (spd > 100 || spd < -100)
					r.status = dsds_pkg::ST_SPEED_BAD;
				else if (c.op == dsds_pkg::OP_DRIVE) begin
					if (dir > 100 || dir < -100)
						r.status = dsds_pkg::ST_DIR_BAD;
					else if (dir < 0)
						launch_run((spd * (100 + dir)) / 100, spd, c.limit);
					else
						launch_run(spd, (spd * (100 - dir)) / 100, c.limit);
				end else if (dir inside {90, -90, 180, -180})
					launch_run(spd, -spd, c.limit);
				else
					r.status = dsds_pkg::ST_DIR_BAD;
			end
		endcase
		r.coils_l = mot_coil[0];
		r.coils_r = mot_coil[1];
		r.running = run_on;
		r.steps_l = mot_steps[0];
		r.steps_r = mot_steps[1];
		return r;
	endfunction

	task automatic send_cmd(input cmd_word_t c, input logic typed, input drive_report_t want);
		drive_report_t r;
		while ($urandom_range(99, 0) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= c.op;
		cmd_ch.speed      <= c.speed;
		cmd_ch.direction  <= c.dir;
		cmd_ch.step_limit <= c.limit;
		do @(posedge clk); while (!cmd_ch.ready);
		r = predict_report(c);
		pending_reports.push_back(typed ? want : r);
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= dsds_pkg::DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == dsds_pkg::REG_MIN_PERIOD)
			min_ms = val;
		else
			max_ms = val;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// result side flow control; a hold request stalls it until hold_cnt runs down
	initial begin
		int hold_seen;
		int hold_cnt;
		hold_seen = 0;
		hold_cnt = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= $urandom_range(99, 0) >= snk_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		drive_report_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_reports.size() == 0) begin
				mismatch_cnt++;
				$error("result transaction with no command outstanding");
			end else begin
				want = pending_reports.pop_front();
				check_field("coils_left", want.coils_l, res_ch.coils_left);
				check_field("coils_right", want.coils_r, res_ch.coils_right);
				check_field("running", want.running, res_ch.running);
				check_field("status", want.status, res_ch.status);
				check_field("steps_left", want.steps_l, res_ch.steps_left);
				check_field("steps_right", want.steps_r, res_ch.steps_right);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		cmd_word_t c;
		int        pick;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.op         <= dsds_pkg::OP_TICK;
		cmd_ch.speed      <= '0;
		cmd_ch.direction  <= '0;
		cmd_ch.step_limit <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset period settings
		src_idle_pct = 12;
		snk_idle_pct = 87;
		foreach (DIRECTED[i])
			send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);

		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			drain_results();
			if (seg < 4) begin
				src_idle_pct = 12;
				snk_idle_pct = 87;
			end else if (seg < 7) begin
				src_idle_pct = 87;
				snk_idle_pct = 12;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			case (seg)
				1: begin
					cfg_write(dsds_pkg::REG_MIN_PERIOD, 16'd0);
					cfg_write(dsds_pkg::REG_MAX_PERIOD, 16'd0);
				end
				3: begin
					cfg_write(dsds_pkg::REG_MIN_PERIOD, 16'hFFFF);
					cfg_write(dsds_pkg::REG_MAX_PERIOD, 16'hFFFF);
				end
				5: begin
					cfg_write(dsds_pkg::REG_MIN_PERIOD, 16'hFFFF);
					cfg_write(dsds_pkg::REG_MAX_PERIOD, 16'd0);
				end
				7: begin
					cfg_write(dsds_pkg::REG_MIN_PERIOD, 16'd0);
					cfg_write(dsds_pkg::REG_MAX_PERIOD, 16'hFFFF);
				end
				default: begin
					cfg_write(dsds_pkg::REG_MIN_PERIOD, 16'($urandom_range(4, 0)));
					cfg_write(dsds_pkg::REG_MAX_PERIOD, 16'($urandom_range(12, 0)));
				end
			endcase
			if (seg == 8)
				hold_requests++;
			repeat (SEG_ITEMS) begin
				pick = $urandom_range(99, 0);
				c.op = pick < 62 ? dsds_pkg::OP_TICK :
					pick < 77 ? dsds_pkg::OP_DRIVE :
					pick < 89 ? dsds_pkg::OP_ROTATE : dsds_pkg::OP_STOP;
				if ($urandom_range(99, 0) < 88)
					c.speed = 8'(int'($urandom_range(200, 0)) - 100);
				else
					c.speed = 8'($urandom);
				if (c.op == dsds_pkg::OP_ROTATE && $urandom_range(99, 0) < 85)
					c.dir = 9'(ROT_ANGLES[$urandom_range(3, 0)]);
				else if ($urandom_range(99, 0) < 85)
					c.dir = 9'(int'($urandom_range(200, 0)) - 100);
				else
					c.dir = 9'($urandom);
				pick = $urandom_range(9, 0);
				c.limit = pick < 3 ? 16'd0 : pick < 8 ? 16'($urandom_range(12, 1))
					: 16'($urandom);
				send_cmd(c, 1'b0, IDLE_REPORT);
			end
		end

		drain_results();
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
